### src/laurent_polynomial_evaluator_core_macros.svh
`ifndef LAURENT_POLYNOMIAL_EVALUATOR_CORE_MACROS_SVH
`define LAURENT_POLYNOMIAL_EVALUATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define LPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lpe assertion failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define LPE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lpe assertion failed");

`endif

### src/lpe_pkg.sv
package lpe_pkg;

    localparam int MAX_DEGREE  = 7;
    localparam int NUM_COEFS   = MAX_DEGREE + 1;
    localparam int PAIR_REGS   = 4;
    localparam int COEF_IDX_W  = $clog2(NUM_COEFS);
    localparam int DEG_W       = 4;
    localparam int X_W         = 16;
    localparam int Q_W         = 32;
    localparam int PROD_W      = Q_W + X_W;
    localparam int FRAC_X      = 12;
    localparam int DIV_BITS    = Q_W + FRAC_X;
    localparam int DIV_CNT_W   = $clog2(DIV_BITS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR0 = 3'd1;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic [COEF_IDX_W-1:0] coef_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_PROD,
        ST_MUL_ACC,
        ST_DIV_INIT,
        ST_DIV_ITER,
        ST_DIV_ACC,
        ST_WRITE
    } lpe_state_t;

    typedef struct packed {
        logic      load;
        logic      mul_prod;
        logic      mul_acc;
        logic      div_init;
        logic      div_iter;
        logic      div_acc;
        logic      write_out;
        coef_idx_t coef_idx;
    } lpe_cmd_t;

    typedef struct packed {
        coef_idx_t deg_mag;
        logic      deg_neg;
        logic      out_free;
    } lpe_status_t;

endpackage

### src/lpe_ctrl.sv
`include "laurent_polynomial_evaluator_core_macros.svh"

module lpe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lpe_pkg::lpe_status_t status,
    output lpe_pkg::lpe_cmd_t    cmd
);
    import lpe_pkg::*;

    lpe_state_t             state_reg, state_next;
    coef_idx_t              k_reg, k_next;
    logic [DIV_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            bit_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        bit_cnt_next = bit_cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.coef_idx = k_reg - coef_idx_t'(1);
        unique case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.coef_idx = status.deg_mag;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    k_next   = status.deg_mag;
                    if (status.deg_mag == '0) begin
                        state_next = ST_WRITE;
                    end else if (status.deg_neg) begin
                        state_next = ST_DIV_INIT;
                    end else begin
                        state_next = ST_MUL_PROD;
                    end
                end
            end
            ST_MUL_PROD: begin
                cmd.mul_prod = 1'b1;
                state_next   = ST_MUL_ACC;
            end
            ST_MUL_ACC: begin
                cmd.mul_acc = 1'b1;
                k_next      = k_reg - coef_idx_t'(1);
                state_next  = (k_reg == coef_idx_t'(1)) ? ST_WRITE : ST_MUL_PROD;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                bit_cnt_next = '0;
                state_next   = ST_DIV_ITER;
            end
            ST_DIV_ITER: begin
                cmd.div_iter = 1'b1;
                if (bit_cnt_reg == DIV_CNT_W'(DIV_BITS - 1)) begin
                    state_next = ST_DIV_ACC;
                end else begin
                    bit_cnt_next = bit_cnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_DIV_ACC: begin
                cmd.div_acc = 1'b1;
                k_next      = k_reg - coef_idx_t'(1);
                state_next  = (k_reg == coef_idx_t'(1)) ? ST_WRITE : ST_DIV_INIT;
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    cmd.write_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LPE_ASSERT_NXT(a_accept_leaves_idle, s_tvalid && s_tready, state_reg != ST_IDLE)
    `LPE_ASSERT_IMP(a_step_has_coef, cmd.mul_acc || cmd.div_acc, k_reg != '0)

endmodule

### src/lpe_datapath.sv
`include "laurent_polynomial_evaluator_core_macros.svh"

module lpe_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [lpe_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lpe_pkg::M_TDATA_W-1:0]     m_tdata,
    input  lpe_pkg::lpe_cmd_t                 cmd,
    output lpe_pkg::lpe_status_t              status
);
    import lpe_pkg::*;

    logic [DEG_W-1:0]          degree_reg;
    logic signed [Q_W-1:0]     coef_reg [NUM_COEFS];
    logic signed [X_W-1:0]     x_reg;
    logic signed [Q_W-1:0]     acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [DIV_BITS-1:0]       quo_reg;
    logic [X_W-1:0]            rem_reg;
    logic [X_W-1:0]            den_reg;
    logic                      neg_q_reg;
    logic                      ovf_reg, ovf_next;
    logic                      dz_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    logic [DEG_W:0]            mag_full;
    logic signed [X_W-1:0]     x_in;
    logic signed [Q_W-1:0]     coef_sel;
    logic signed [PROD_W:0]    prod_rnd;
    logic signed [Q_W-1:0]     step_val;
    logic                      step_ovf;
    logic signed [Q_W:0]       sum_val;
    logic [X_W:0]              trial;
    logic                      trial_ge;
    logic [Q_W-1:0]            acc_abs;
    logic [X_W-1:0]            x_abs;

    assign x_in     = $signed(s_tdata[X_W-1:0]);
    assign mag_full = degree_reg[DEG_W-1] ? (DEG_W+1)'(0) - {degree_reg[DEG_W-1], degree_reg}
                                          : {1'b0, degree_reg};
    assign status.deg_neg  = degree_reg[DEG_W-1];
    assign status.deg_mag  = (mag_full > (DEG_W+1)'(MAX_DEGREE)) ? COEF_IDX_W'(MAX_DEGREE)
                                                                 : COEF_IDX_W'(mag_full);
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign coef_sel = coef_reg[cmd.coef_idx];
    assign acc_abs  = acc_reg[Q_W-1] ? Q_W'(0) - Q_W'(acc_reg) : Q_W'(acc_reg);
    assign x_abs    = x_reg[X_W-1] ? X_W'(0) - X_W'(x_reg) : X_W'(x_reg);
    assign prod_rnd = $signed({prod_reg[PROD_W-1], prod_reg}) + (PROD_W+1)'(2048);
    assign trial    = {rem_reg, quo_reg[DIV_BITS-1]};
    assign trial_ge = trial >= {1'b0, den_reg};

    always_comb begin
        step_val = '0;
        step_ovf = 1'b0;
        if (cmd.mul_acc) begin
            if (prod_rnd[PROD_W:Q_W+FRAC_X-1] != '0 && prod_rnd[PROD_W:Q_W+FRAC_X-1] != '1) begin
                step_val = prod_rnd[PROD_W] ? Q_MIN : Q_MAX;
                step_ovf = 1'b1;
            end else begin
                step_val = prod_rnd[Q_W+FRAC_X-1:FRAC_X];
            end
        end else if (x_reg == '0) begin
            if (acc_reg > 0) begin
                step_val = Q_MAX;
                step_ovf = 1'b1;
            end else if (acc_reg < 0) begin
                step_val = Q_MIN;
                step_ovf = 1'b1;
            end
        end else if (neg_q_reg) begin
            if (quo_reg > DIV_BITS'({1'b1, {(Q_W-1){1'b0}}})) begin
                step_val = Q_MIN;
                step_ovf = 1'b1;
            end else begin
                step_val = $signed(Q_W'(0) - quo_reg[Q_W-1:0]);
            end
        end else begin
            if (quo_reg > DIV_BITS'(Q_MAX)) begin
                step_val = Q_MAX;
                step_ovf = 1'b1;
            end else begin
                step_val = $signed(quo_reg[Q_W-1:0]);
            end
        end
    end

    always_comb begin
        sum_val  = {step_val[Q_W-1], step_val} + {coef_sel[Q_W-1], coef_sel};
        acc_next = sum_val[Q_W-1:0];
        ovf_next = ovf_reg | step_ovf;
        if (sum_val[Q_W] != sum_val[Q_W-1]) begin
            acc_next = sum_val[Q_W] ? Q_MIN : Q_MAX;
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= '0;
            for (int i = 0; i < NUM_COEFS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_DEGREE) begin
                degree_reg <= cfg_data[DEG_W-1:0];
            end
            for (int p = 0; p < PAIR_REGS; p++) begin
                if (cfg_index == REG_COEF_PAIR0 + CFG_IDX_W'(p)) begin
                    if (2 * p <= MAX_DEGREE) begin
                        coef_reg[2*p] <= $signed(cfg_data[Q_W-1:0]);
                    end
                    if (2 * p + 1 <= MAX_DEGREE) begin
                        coef_reg[2*p+1] <= $signed(cfg_data[2*Q_W-1:Q_W]);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg   <= x_in;
            acc_reg <= coef_sel;
            ovf_reg <= 1'b0;
            dz_reg  <= status.deg_neg && (x_in == '0);
        end
        if (cmd.mul_prod) begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(x_reg);
        end
        if (cmd.mul_acc || cmd.div_acc) begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
        end
        if (cmd.div_init) begin
            quo_reg   <= {acc_abs, {FRAC_X{1'b0}}} + DIV_BITS'(x_abs >> 1);
            rem_reg   <= '0;
            den_reg   <= x_abs;
            neg_q_reg <= acc_reg[Q_W-1] ^ x_reg[X_W-1];
        end
        if (cmd.div_iter) begin
            quo_reg <= {quo_reg[DIV_BITS-2:0], trial_ge};
            rem_reg <= trial_ge ? X_W'(trial - {1'b0, den_reg}) : X_W'(trial);
        end
        if (cmd.write_out) begin
            m_tdata_reg <= {{(M_TDATA_W-Q_W-2){1'b0}}, dz_reg, ovf_reg, acc_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.write_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `LPE_ASSERT_IMP(a_no_overwrite, cmd.write_out, !m_tvalid_reg || m_tready)
    `LPE_ASSERT_NXT(a_write_shows, cmd.write_out, m_tvalid_reg)

endmodule

### src/laurent_polynomial_evaluator_core.sv
// Laurent polynomial evaluator: one Q16.16 result per Q3.12 point x.
// Input stream: s_tdata[15:0] = x_value, taken when s_tvalid and s_tready are high.
// Output stream: m_tdata[31:0] = poly_value, [32] = overflow, [33] = div_by_zero,
// [39:34] zero. One result beat per input beat, in order.
// Config: cfg_wr_en with cfg_index 0 = degree (cfg_data[3:0], signed), 1..4 =
// coefficient pairs (low word even coefficient, high word odd). Write only while idle.
// One point is in work at a time; s_tready is high only when the engine is idle.
// After accept the engine runs m steps (m = degree magnitude, capped at 7), then
// waits in its write state until the output register is free and writes the result.
// The engine is idle again in the cycle after the write.
// A positive-degree step is a multiply state followed by a round/saturate/add state.
// A negative-degree step runs a restoring divider at one quotient bit per cycle
// over 44 bits, plus setup and round/saturate/add cycles.
// The result sits in an output register, so the next point is accepted while a
// result waits; a stalled receiver holds the engine at its final step only when
// the next result is ready and the register is still full.
// Reset (aresetn low, synchronous) clears degree and coefficients to zero, empties
// the output register and returns the engine to idle.
module laurent_polynomial_evaluator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lpe_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] x_value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lpe_pkg::M_TDATA_W-1:0]  m_tdata    // [31:0] poly_value, [32] overflow,
                                                      // [33] div_by_zero
);
    import lpe_pkg::*;

    lpe_cmd_t    cmd;
    lpe_status_t status;

    lpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lpe_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### verif/lpe_result_checker.sv
module lpe_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lpe_pkg::S_TDATA_W-1:0]  s_tdata,    // [15:0] x_value
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lpe_pkg::M_TDATA_W-1:0]  m_tdata,    // [31:0] poly_value, [32] overflow,
                                                       // [33] div_by_zero
    output int                             mismatches,
    output int                             pending,
    output int                             checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import lpe_pkg::*;

    typedef struct packed {
        logic signed [Q_W-1:0] poly;
        logic                  ovf;
        logic                  dz;
    } poly_result_t;

    localparam logic signed [63:0] WIDE_MAX = Q_MAX;
    localparam logic signed [63:0] WIDE_MIN = Q_MIN;

    logic [DEG_W-1:0]      degree_reg;
    logic signed [Q_W-1:0] coef_reg [NUM_COEFS];
    poly_result_t          expected_q [$];
    int                    bad_count = 0;
    int                    seen_count = 0;

    function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [63:0] v,
                                                      inout logic ovf);
        if (v > WIDE_MAX) begin
            ovf = 1'b1;
            return Q_MAX;
        end
        if (v < WIDE_MIN) begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return v[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] mul_round(input logic signed [Q_W-1:0] acc,
                                                        input logic signed [X_W-1:0] x,
                                                        inout logic ovf);
        logic signed [63:0] p;
        p = acc * x;
        p = (p + 64'sd2048) >>> FRAC_X;
        return clamp_q(p, ovf);
    endfunction

    function automatic logic signed [Q_W-1:0] div_round(input logic signed [Q_W-1:0] acc,
                                                        input logic signed [X_W-1:0] x,
                                                        inout logic ovf);
        logic signed [63:0] a;
        logic signed [63:0] xs;
        logic signed [63:0] qs;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        q;
        logic               neg;
        if (x == 0) begin
            if (acc > 0) begin
                ovf = 1'b1;
                return Q_MAX;
            end
            if (acc < 0) begin
                ovf = 1'b1;
                return Q_MIN;
            end
            return '0;
        end
        a = acc;
        xs = x;
        num = (a < 0) ? -a : a;
        num = num << FRAC_X;
        den = (xs < 0) ? -xs : xs;
        neg = (acc < 0) != (x < 0);
        q = (num + (den >> 1)) / den;
        qs = $signed(q);
        if (neg) begin
            qs = -qs;
        end
        return clamp_q(qs, ovf);
    endfunction

    function automatic poly_result_t evaluate_point(input logic signed [X_W-1:0] x);
        int                    d;
        int                    mag;
        logic signed [Q_W-1:0] acc;
        logic signed [Q_W-1:0] stepv;
        logic signed [63:0]    wide;
        logic                  ovf;
        poly_result_t          r;
        d = $signed(degree_reg);
        if (d > MAX_DEGREE) d = MAX_DEGREE;
        if (d < -MAX_DEGREE) d = -MAX_DEGREE;
        mag = (d < 0) ? -d : d;
        ovf = 1'b0;
        acc = coef_reg[mag];
        for (int k = mag - 1; k >= 0; k--) begin
            if (d > 0) begin
                stepv = mul_round(acc, x, ovf);
            end else begin
                stepv = div_round(acc, x, ovf);
            end
            wide = stepv;
            wide = wide + coef_reg[k];
            acc = clamp_q(wide, ovf);
        end
        r.poly = acc;
        r.ovf = ovf;
        r.dz = (d < 0) && (x == 0);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        poly_result_t want;
        poly_result_t got;
        logic [M_TDATA_W-Q_W-3:0] pad;
        int k;
        if (!aresetn) begin
            degree_reg = '0;
            foreach (coef_reg[i]) coef_reg[i] = '0;
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(evaluate_point(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.poly = m_tdata[Q_W-1:0];
                got.ovf = m_tdata[Q_W];
                got.dz = m_tdata[Q_W+1];
                pad = m_tdata[M_TDATA_W-1:Q_W+2];
                if (expected_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display("beat %0d with no point pending: poly=%h ovf=%b dz=%b",
                                 seen_count, got.poly, got.ovf, got.dz);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (want.poly != got.poly || want.ovf != got.ovf || want.dz != got.dz
                        || pad != '0) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("beat %0d: expected %h/%b/%b, got %h/%b/%b pad=%h",
                                     seen_count, want.poly, want.ovf, want.dz,
                                     got.poly, got.ovf, got.dz, pad);
                        end
                    end
                end
                seen_count++;
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_DEGREE) begin
                    degree_reg = cfg_data[DEG_W-1:0];
                end else if (cfg_index >= REG_COEF_PAIR0
                             && cfg_index < REG_COEF_PAIR0 + PAIR_REGS) begin
                    k = 2 * (cfg_index - REG_COEF_PAIR0);
                    coef_reg[k] = cfg_data[Q_W-1:0];
                    coef_reg[k+1] = cfg_data[2*Q_W-1:Q_W];
                end
            end
        end
        mismatches <= bad_count;
        pending <= expected_q.size();
        checked <= seen_count;
    end

endmodule

### verif/laurent_polynomial_evaluator_core_test.sv
module laurent_polynomial_evaluator_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lpe_pkg::*;

    localparam int RUN_LIMIT     = 1_500_000;
    localparam int RANDOM_POINTS = 900;
    localparam int REG_SPARE_FIRST = REG_COEF_PAIR0 + PAIR_REGS;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [M_TDATA_W-1:0]  m_tdata;

    int               mismatches;
    int               pending;
    int               checked;
    int               sent_points = 0;
    int               settings_used = 0;
    int               cycle_count = 0;
    int               stall_left = 0;
    bit               quiet = 1'b0;
    logic [DEG_W-1:0] deg_plan = '0;
    logic [Q_W-1:0]   coef_plan [NUM_COEFS];

    laurent_polynomial_evaluator_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lpe_result_checker result_watch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("laurent_polynomial_evaluator_core_test NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            stall_left = quiet ? 0 : $urandom_range(0, 8);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        m_tready <= (stall_left == 0);
    end

    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data <= data;
        @(posedge aclk);
    endtask

    task automatic program_setting(input bit partial);
        logic [CFG_DATA_W-1:0] word;
        word = {$urandom, $urandom};
        word[DEG_W-1:0] = deg_plan;
        if (!partial || $urandom_range(0, 4) != 0) begin
            write_reg(REG_DEGREE, word);
        end
        for (int r = 0; r < PAIR_REGS; r++) begin
            if (!partial || $urandom_range(0, 3) != 0) begin
                write_reg(REG_COEF_PAIR0 + r, {coef_plan[2*r+1], coef_plan[2*r]});
            end
        end
        if (partial && $urandom_range(0, 3) == 0) begin
            write_reg(REG_SPARE_FIRST + $urandom_range(0, 2), {$urandom, $urandom});
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic fill_coefs(input logic [Q_W-1:0] even_val, input logic [Q_W-1:0] odd_val);
        foreach (coef_plan[k]) coef_plan[k] = k[0] ? odd_val : even_val;
    endtask

    task automatic send_point(input logic [X_W-1:0] x);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
        sent_points++;
    endtask

    // drop valid in the step of the last beat, then wait out every result
    task automatic end_phase();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [Q_W-1:0] rand_coef();
        logic signed [Q_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = Q_MAX;
            1: v = Q_MIN;
            2: v = '0;
            default: begin
                v = $urandom;
                v = v >>> $urandom_range(0, 31);
            end
        endcase
        return v;
    endfunction

    function automatic logic [X_W-1:0] rand_point();
        logic signed [X_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 16'h7FFF;
            2: v = 16'h8000;
            3: v = 16'sd4096;
            4: v = -16'sd4096;
            5, 6: v = $urandom;
            default: begin
                v = $urandom;
                v = v >>> $urandom_range(1, 8);
            end
        endcase
        return v;
    endfunction

    initial begin : stimulus
        int goal;
        int phase_len;
        foreach (coef_plan[k]) coef_plan[k] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state: degree zero, all coefficients zero
        send_point(16'h1234);
        end_phase();

        deg_plan = 4'd7;
        fill_coefs(Q_MAX, Q_MAX);
        program_setting(1'b0);
        send_point(16'h7FFF);
        send_point(16'h8000);
        send_point(16'h0000);
        send_point(16'h0001);
        end_phase();

        // register value -8 saturates to the deepest inverse polynomial
        deg_plan = 4'h8;
        fill_coefs(32'h0001_8000, Q_MIN);
        program_setting(1'b0);
        send_point(16'h0000);
        send_point(16'h0001);
        send_point(16'hFFFF);
        send_point(16'h7FFF);
        send_point(16'h8000);
        end_phase();

        // divide by zero with zero, positive and negative dividends
        deg_plan = 4'hF;
        fill_coefs(32'h0002_0000, 32'h0000_0000);
        program_setting(1'b0);
        send_point(16'h0000);
        send_point(16'd4096);
        end_phase();
        fill_coefs(32'h0002_0000, 32'h0001_0000);
        program_setting(1'b0);
        send_point(16'h0000);
        end_phase();
        fill_coefs(32'h0002_0000, 32'hFFFF_0000);
        program_setting(1'b0);
        send_point(16'h0000);
        end_phase();

        deg_plan = 4'd0;
        fill_coefs(Q_MIN, 32'h1234_5678);
        program_setting(1'b0);
        send_point(16'h8000);
        send_point(16'h0000);
        end_phase();

        deg_plan = 4'd1;
        fill_coefs(Q_MAX, Q_MAX);
        program_setting(1'b0);
        send_point(16'd4096);
        end_phase();

        deg_plan = 4'd7;
        fill_coefs(32'h0000_C000, 32'hFFFF_6000);
        program_setting(1'b0);
        send_point(16'hF000);
        send_point(16'h0800);
        send_point(16'hFFFF);
        end_phase();

        goal = sent_points + RANDOM_POINTS;
        while (sent_points < goal) begin
            quiet = ($urandom_range(0, 3) == 0);
            deg_plan = $urandom_range(0, 15);
            foreach (coef_plan[k]) coef_plan[k] = rand_coef();
            program_setting(1'b1);
            phase_len = $urandom_range(10, 50);
            repeat (phase_len) send_point(rand_point());
            end_phase();
        end

        repeat (8) @(posedge aclk);
        $display("covered %0d points over %0d register settings, degrees drawn from -8..7",
                 sent_points, settings_used);
        $display("%0d result beats checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("laurent_polynomial_evaluator_core_test OK");
        end else begin
            $display("laurent_polynomial_evaluator_core_test NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/lpe_pkg.sv
src/lpe_ctrl.sv
src/lpe_datapath.sv
src/laurent_polynomial_evaluator_core.sv
verif/lpe_result_checker.sv
verif/laurent_polynomial_evaluator_core_test.sv
